// ===== design/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// Perspective projection package
// Shared widths, register indexes, constants and item types.
// ----------------------------------------------------------------------------
package ppp_pkg;

   localparam int COORD_W   = 32;
   localparam int QUAT_W    = 16;
   localparam int MAT_W     = 32;
   localparam int VEC_W     = 34;
   localparam int PIX_W     = 24;
   localparam int CENTER_W  = 14;
   localparam int DIV_STEPS = 25;
   localparam int P16_W     = 51;
   localparam int REM_W     = 34;
   localparam int RZ_W      = 33;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] REG_CAM_X = 3'd0;
   localparam logic [2:0] REG_CAM_Y = 3'd1;
   localparam logic [2:0] REG_CAM_Z = 3'd2;
   localparam logic [2:0] REG_ROT_W = 3'd3;
   localparam logic [2:0] REG_ROT_I = 3'd4;
   localparam logic [2:0] REG_ROT_J = 3'd5;
   localparam logic [2:0] REG_ROT_K = 3'd6;
   localparam logic [2:0] REG_FOCAL = 3'd7;

   localparam logic signed [QUAT_W-1:0] QUAT_ONE  = 16'sd16384;
   localparam logic signed [QUAT_W-1:0] QUAT_MONE = -16'sd16384;
   localparam logic [COORD_W-1:0] FOCAL_RESET = 32'd53225718;
   localparam logic signed [VEC_W-1:0] VEC_LIM = 34'sd8589934591;
   localparam logic signed [PIX_W-1:0] BEHIND_PIXEL = -24'sd1000;
   localparam logic signed [PIX_W-1:0] PIX_MAX = 24'sd8388607;
   localparam logic signed [PIX_W-1:0] PIX_MIN = -24'sd8388608;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } point_type;

   typedef struct packed {
      logic signed [PIX_W-1:0] pixel_x;
      logic signed [PIX_W-1:0] pixel_y;
      logic                    behind_flag;
   } pixel_type;

   typedef struct packed {
      logic [REM_W-1:0]     rem;
      logic [DIV_STEPS-1:0] dl;
      logic [DIV_STEPS-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic       behind;
      logic [1:0] neg;
      logic [1:0] frac_low;
      logic [1:0] sat;
   } proj_side_type;

endpackage

// ===== design/ppp_rotate.sv =====
// ----------------------------------------------------------------------------
// Rotation pass
// One matrix by vector product in three stages: split partial products,
// product assembly with rounding to Q16.16, and row sum with saturation.
// ----------------------------------------------------------------------------
module ppp_rotate (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic signed [ppp_pkg::VEC_W-1:0] vec_in [3],
   input  logic signed [ppp_pkg::MAT_W-1:0] mat [9],
   output logic                             out_valid,
   output logic signed [ppp_pkg::VEC_W-1:0] vec_out [3]
);
   import ppp_pkg::*;

   localparam int LO_W   = 17;
   localparam int HI_W   = VEC_W - LO_W;
   localparam int PLO_W  = MAT_W + LO_W + 1;
   localparam int PHI_W  = MAT_W + HI_W;
   localparam int FULL_W = MAT_W + VEC_W;
   localparam int RND_W  = FULL_W - 28;
   localparam int SUM_W  = RND_W + 2;
   localparam logic signed [FULL_W-1:0] RND_HALF = {{(FULL_W-28){1'b0}}, 1'b1, 27'b0};

   logic signed [PLO_W-1:0] plo_ff [9];
   logic signed [PLO_W-1:0] plo_in [9];
   logic signed [PHI_W-1:0] phi_ff [9];
   logic signed [PHI_W-1:0] phi_in [9];
   logic signed [RND_W-1:0] rnd_ff [9];
   logic signed [RND_W-1:0] rnd_in [9];
   logic signed [VEC_W-1:0] vec_ff [3];
   logic signed [VEC_W-1:0] vec_in_c [3];
   logic [2:0] valid_ff;
   logic [2:0] valid_in;

   always_comb begin
      logic signed [FULL_W-1:0] full;
      logic signed [FULL_W-1:0] t;
      logic signed [SUM_W-1:0]  s;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            plo_in[r*3+c] = mat[r*3+c] * $signed({1'b0, vec_in[c][LO_W-1:0]});
            phi_in[r*3+c] = mat[r*3+c] * $signed(vec_in[c][VEC_W-1:LO_W]);
         end
      end
      for (int i = 0; i < 9; i++) begin
         full      = (FULL_W'(phi_ff[i]) <<< LO_W) + FULL_W'(plo_ff[i]);
         t         = full + RND_HALF;
         rnd_in[i] = t[FULL_W-1:28];
      end
      for (int r = 0; r < 3; r++) begin
         s = SUM_W'(rnd_ff[r*3]) + SUM_W'(rnd_ff[r*3+1]) + SUM_W'(rnd_ff[r*3+2]);
         if (s > SUM_W'(VEC_LIM)) begin
            vec_in_c[r] = VEC_LIM;
         end else if (s < -SUM_W'(VEC_LIM)) begin
            vec_in_c[r] = -VEC_LIM;
         end else begin
            vec_in_c[r] = s[VEC_W-1:0];
         end
      end
   end

   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      rnd_ff <= rnd_in;
      vec_ff <= vec_in_c;
   end

   assign out_valid = valid_ff[2];
   assign vec_out   = vec_ff;

endmodule

// ===== design/ppp_div.sv =====
// ----------------------------------------------------------------------------
// Depth divider
// Restoring divider, one quotient bit per stage, two lanes sharing one
// divisor, with the side flags carried alongside.
// ----------------------------------------------------------------------------
module ppp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [ppp_pkg::RZ_W-1:0]     rz,
   input  ppp_pkg::proj_side_type       side_in,
   input  ppp_pkg::div_lane_type        lane_in [2],
   output logic                         out_valid,
   output ppp_pkg::proj_side_type       side_out,
   output ppp_pkg::div_lane_type        lane_out [2]
);
   import ppp_pkg::*;

   function automatic div_lane_type div_step(input div_lane_type l,
                                             input logic [RZ_W-1:0] d);
      logic [REM_W:0] t;
      logic [REM_W:0] dx;
      div_lane_type   r;
      t  = {l.rem, l.dl[DIV_STEPS-1]};
      dx = {2'b0, d};
      r  = l;
      r.dl = l.dl << 1;
      if (t >= dx) begin
         r.rem = REM_W'(t - dx);
         r.quo = {l.quo[DIV_STEPS-2:0], 1'b1};
      end else begin
         r.rem = t[REM_W-1:0];
         r.quo = {l.quo[DIV_STEPS-2:0], 1'b0};
      end
      return r;
   endfunction

   div_lane_type  lane_ff [DIV_STEPS][2];
   div_lane_type  lane_nx [DIV_STEPS][2];
   logic [RZ_W-1:0] rz_ff [DIV_STEPS];
   logic [RZ_W-1:0] rz_nx [DIV_STEPS];
   proj_side_type side_ff [DIV_STEPS];
   proj_side_type side_nx [DIV_STEPS];
   logic [DIV_STEPS-1:0] valid_ff;
   logic [DIV_STEPS-1:0] valid_in;

   always_comb begin
      for (int s = 0; s < DIV_STEPS; s++) begin
         if (s == 0) begin
            rz_nx[s]   = rz;
            side_nx[s] = side_in;
            for (int l = 0; l < 2; l++) begin
               lane_nx[s][l] = div_step(lane_in[l], rz);
            end
         end else begin
            rz_nx[s]   = rz_ff[s-1];
            side_nx[s] = side_ff[s-1];
            for (int l = 0; l < 2; l++) begin
               lane_nx[s][l] = div_step(lane_ff[s-1][l], rz_ff[s-1]);
            end
         end
      end
   end

   assign valid_in = {valid_ff[DIV_STEPS-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff <= lane_nx;
      rz_ff   <= rz_nx;
      side_ff <= side_nx;
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign side_out  = side_ff[DIV_STEPS-1];
   assign lane_out  = lane_ff[DIV_STEPS-1];

endmodule

// ===== design/ppp_project.sv =====
// ----------------------------------------------------------------------------
// Perspective divide
// Scales the rotated x and y by the focal factor, divides by depth,
// adds the image center and saturates to pixel range.
// ----------------------------------------------------------------------------
module ppp_project (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic signed [ppp_pkg::VEC_W-1:0] vec_in [3],
   input  logic [ppp_pkg::COORD_W-1:0]      focal,
   input  logic [ppp_pkg::CENTER_W-1:0]     center_x,
   input  logic [ppp_pkg::CENTER_W-1:0]     center_y,
   output logic                             out_valid,
   output ppp_pkg::pixel_type               out_item
);
   import ppp_pkg::*;

   localparam int HP_W  = COORD_W + VEC_W - 16;
   localparam int LP_W  = COORD_W + 16;
   localparam int CMP_W = RZ_W + DIV_STEPS + 1;
   localparam int RES_W = PIX_W + 3;

   // Stage one: magnitudes and split focal products.
   logic [HP_W-1:0] hp_ff [2];
   logic [HP_W-1:0] hp_in [2];
   logic [LP_W-1:0] lp_ff [2];
   logic [LP_W-1:0] lp_in [2];
   logic [1:0]      neg1_ff;
   logic [1:0]      neg1_in;
   logic            behind1_ff;
   logic [RZ_W-1:0] rz1_ff;

   // Stage two: assembled scaled numerators.
   logic [P16_W-1:0] p16_ff [2];
   logic [P16_W-1:0] p16_in [2];
   logic [1:0]       neg2_ff;
   logic [1:0]       fracl2_ff;
   logic [1:0]       fracl2_in;
   logic             behind2_ff;
   logic [RZ_W-1:0]  rz2_ff;

   // Stage three: overflow check and divider set-up.
   div_lane_type  lane3_ff [2];
   div_lane_type  lane3_in [2];
   proj_side_type side3_ff;
   proj_side_type side3_in;
   logic [RZ_W-1:0] rz3_ff;

   logic [2:0] valid_ff;
   logic [2:0] valid_in;

   logic          div_valid;
   proj_side_type div_side;
   div_lane_type  div_lane [2];

   pixel_type out_ff;
   pixel_type out_in;
   logic      out_valid_ff;

   always_comb begin
      logic [VEC_W-1:0] mag;
      for (int l = 0; l < 2; l++) begin
         neg1_in[l] = vec_in[l][VEC_W-1];
         mag        = neg1_in[l] ? VEC_W'(-vec_in[l]) : VEC_W'(vec_in[l]);
         hp_in[l]   = HP_W'(focal) * HP_W'(mag[VEC_W-1:16]);
         lp_in[l]   = LP_W'(focal) * LP_W'(mag[15:0]);
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         p16_in[l]    = P16_W'(hp_ff[l]) + P16_W'(lp_ff[l][LP_W-1:16]);
         fracl2_in[l] = (lp_ff[l][15:0] != 16'd0);
      end
   end

   always_comb begin
      side3_in.behind   = behind2_ff;
      side3_in.neg      = neg2_ff;
      side3_in.frac_low = fracl2_ff;
      for (int l = 0; l < 2; l++) begin
         side3_in.sat[l] = (CMP_W'(p16_ff[l]) >= {1'b0, rz2_ff, {DIV_STEPS{1'b0}}});
         lane3_in[l].rem = REM_W'(p16_ff[l][P16_W-1:DIV_STEPS]);
         lane3_in[l].dl  = p16_ff[l][DIV_STEPS-1:0];
         lane3_in[l].quo = '0;
      end
   end

   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hp_ff      <= hp_in;
      lp_ff      <= lp_in;
      neg1_ff    <= neg1_in;
      behind1_ff <= vec_in[2][VEC_W-1] | (vec_in[2] == '0);
      rz1_ff     <= vec_in[2][RZ_W-1:0];
      p16_ff     <= p16_in;
      neg2_ff    <= neg1_ff;
      fracl2_ff  <= fracl2_in;
      behind2_ff <= behind1_ff;
      rz2_ff     <= rz1_ff;
      lane3_ff   <= lane3_in;
      side3_ff   <= side3_in;
      rz3_ff     <= rz2_ff;
   end

   ppp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ff[2]),
      .rz        (rz3_ff),
      .side_in   (side3_ff),
      .lane_in   (lane3_ff),
      .out_valid (div_valid),
      .side_out  (div_side),
      .lane_out  (div_lane)
   );

   always_comb begin
      logic signed [RES_W-1:0] cext;
      logic signed [RES_W-1:0] qext;
      logic signed [RES_W-1:0] res;
      logic signed [PIX_W-1:0] pix [2];
      logic                    frac;
      for (int l = 0; l < 2; l++) begin
         cext = (l == 0) ? {{(RES_W-CENTER_W){1'b0}}, center_x}
                         : {{(RES_W-CENTER_W){1'b0}}, center_y};
         qext = {{(RES_W-DIV_STEPS){1'b0}}, div_lane[l].quo};
         frac = (div_lane[l].rem != '0) | div_side.frac_low[l];
         if (div_side.neg[l]) begin
            res = cext - qext;
            if (frac && (res > 0)) begin
               res = res - RES_W'(1);
            end
         end else begin
            res = cext + qext;
         end
         if (div_side.sat[l]) begin
            pix[l] = div_side.neg[l] ? PIX_MIN : PIX_MAX;
         end else if (res > RES_W'(PIX_MAX)) begin
            pix[l] = PIX_MAX;
         end else if (res < RES_W'(PIX_MIN)) begin
            pix[l] = PIX_MIN;
         end else begin
            pix[l] = res[PIX_W-1:0];
         end
      end
      if (div_side.behind) begin
         out_in.pixel_x     = BEHIND_PIXEL;
         out_in.pixel_y     = BEHIND_PIXEL;
         out_in.behind_flag = 1'b1;
      end else begin
         out_in.pixel_x     = pix[0];
         out_in.pixel_y     = pix[1];
         out_in.behind_flag = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

endmodule

// ===== design/perspective_project_point_unit.sv =====
// ----------------------------------------------------------------------------
// Perspective projection unit
// Camera-space transform by quaternion and pinhole projection of 3D points.
// ----------------------------------------------------------------------------
// The unit takes one world point per clock cycle whenever start is raised
// and busy is low. Busy rises only in the cycle after a write to a
// quaternion register, while the rotation matrix catches up; the pipeline
// itself has no stall path. Each item comes back as one result on rsp_item,
// marked by rsp_valid for a single cycle, in order. The pipeline is made of
// one input register, two rotation passes of three stages each, three
// scaling stages, the 25-stage restoring divider that forms one quotient
// bit per stage, and the output register. The receiver cannot hold results
// off and must take each one in the cycle it is shown. The rotation matrix
// is rebuilt from the quaternion registers in two register stages, the
// pairwise products and then the matrix entries; configuration should only
// be written while no item is in flight.
// ----------------------------------------------------------------------------
module perspective_project_point_unit #(
   parameter int IMAGE_WIDTH  = 1920,
   parameter int IMAGE_HEIGHT = 1080
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ppp_pkg::point_type                req_item,
   output logic                              rsp_valid,
   output ppp_pkg::pixel_type                rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ppp_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ppp_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ppp_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import ppp_pkg::*;

   localparam logic [CENTER_W-1:0] CENTER_X = CENTER_W'(IMAGE_WIDTH / 2);
   localparam logic [CENTER_W-1:0] CENTER_Y = CENTER_W'(IMAGE_HEIGHT / 2);
   localparam logic signed [MAT_W-1:0] MAT_ONE = 32'sd268435456;

   // Configuration registers.
   logic signed [COORD_W-1:0] cam_ff [3];
   logic signed [QUAT_W-1:0]  rot_ff [4];
   logic [COORD_W-1:0]        focal_ff;
   logic                      csr_write;
   logic [2:0]                csr_index;
   logic                      quat_hold_ff;

   assign pready    = 1'b1;
   assign busy      = quat_hold_ff;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_ff   <= '{default: '0};
         rot_ff   <= '{QUAT_ONE, '0, '0, '0};
         focal_ff <= FOCAL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_CAM_X: cam_ff[0] <= pwdata;
            REG_CAM_Y: cam_ff[1] <= pwdata;
            REG_CAM_Z: cam_ff[2] <= pwdata;
            REG_ROT_W: rot_ff[0] <= pwdata[QUAT_W-1:0];
            REG_ROT_I: rot_ff[1] <= pwdata[QUAT_W-1:0];
            REG_ROT_J: rot_ff[2] <= pwdata[QUAT_W-1:0];
            REG_ROT_K: rot_ff[3] <= pwdata[QUAT_W-1:0];
            REG_FOCAL: focal_ff  <= pwdata;
            default:   focal_ff  <= focal_ff;
         endcase
      end
   end

   // An item accepted right after a quaternion write would meet the old
   // matrix in the first rotation stage, so intake pauses.
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_hold_ff <= 1'b0;
      end else begin
         quat_hold_ff <= csr_write & (csr_index >= REG_ROT_W) & (csr_index <= REG_ROT_K);
      end
   end

   always_comb begin
      case (csr_index)
         REG_CAM_X: prdata = cam_ff[0];
         REG_CAM_Y: prdata = cam_ff[1];
         REG_CAM_Z: prdata = cam_ff[2];
         REG_ROT_W: prdata = {16'd0, rot_ff[0]};
         REG_ROT_I: prdata = {16'd0, rot_ff[1]};
         REG_ROT_J: prdata = {16'd0, rot_ff[2]};
         REG_ROT_K: prdata = {16'd0, rot_ff[3]};
         REG_FOCAL: prdata = focal_ff;
         default:   prdata = '0;
      endcase
   end

   // Rotation matrix: the quaternion is clamped to plus or minus one, its
   // pairwise products are registered, then the nine Q.28 entries.
   logic signed [QUAT_W-1:0] qc [4];
   logic signed [MAT_W-1:0]  qp_ff [9];
   logic signed [MAT_W-1:0]  qp_in [9];
   logic signed [MAT_W-1:0]  mat_ff [9];
   logic signed [MAT_W-1:0]  mat_in [9];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (rot_ff[i] > QUAT_ONE) begin
            qc[i] = QUAT_ONE;
         end else if (rot_ff[i] < QUAT_MONE) begin
            qc[i] = QUAT_MONE;
         end else begin
            qc[i] = rot_ff[i];
         end
      end
      // Order: xx, yy, zz, xy, xz, yz, wx, wy, wz.
      qp_in[0] = qc[1] * qc[1];
      qp_in[1] = qc[2] * qc[2];
      qp_in[2] = qc[3] * qc[3];
      qp_in[3] = qc[1] * qc[2];
      qp_in[4] = qc[1] * qc[3];
      qp_in[5] = qc[2] * qc[3];
      qp_in[6] = qc[0] * qc[1];
      qp_in[7] = qc[0] * qc[2];
      qp_in[8] = qc[0] * qc[3];
   end

   always_comb begin
      mat_in[0] = MAT_ONE - ((qp_ff[1] + qp_ff[2]) <<< 1);
      mat_in[1] = (qp_ff[3] - qp_ff[8]) <<< 1;
      mat_in[2] = (qp_ff[4] + qp_ff[7]) <<< 1;
      mat_in[3] = (qp_ff[3] + qp_ff[8]) <<< 1;
      mat_in[4] = MAT_ONE - ((qp_ff[0] + qp_ff[2]) <<< 1);
      mat_in[5] = (qp_ff[5] - qp_ff[6]) <<< 1;
      mat_in[6] = (qp_ff[4] - qp_ff[7]) <<< 1;
      mat_in[7] = (qp_ff[5] + qp_ff[6]) <<< 1;
      mat_in[8] = MAT_ONE - ((qp_ff[0] + qp_ff[1]) <<< 1);
   end

   // Both stages start from the identity orientation so that an item taken
   // in the first cycle after reset already sees a valid matrix.
   always_ff @(posedge clock) begin
      if (reset) begin
         qp_ff  <= '{default: '0};
         mat_ff <= '{MAT_ONE, '0, '0, '0, MAT_ONE, '0, '0, '0, MAT_ONE};
      end else begin
         qp_ff  <= qp_in;
         mat_ff <= mat_in;
      end
   end

   // Input stage: offset from the camera position.
   logic signed [VEC_W-1:0] d_ff [3];
   logic signed [VEC_W-1:0] d_in [3];
   logic                    d_valid_ff;

   always_comb begin
      d_in[0] = VEC_W'(req_item.point_x) - VEC_W'(cam_ff[0]);
      d_in[1] = VEC_W'(req_item.point_y) - VEC_W'(cam_ff[1]);
      d_in[2] = VEC_W'(req_item.point_z) - VEC_W'(cam_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      d_ff <= d_in;
   end

   // The rotation is applied twice, each pass rounding and saturating.
   logic                    r1_valid;
   logic signed [VEC_W-1:0] r1 [3];
   logic                    r2_valid;
   logic signed [VEC_W-1:0] r2 [3];

   ppp_rotate u_rotate_first (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid_ff),
      .vec_in    (d_ff),
      .mat       (mat_ff),
      .out_valid (r1_valid),
      .vec_out   (r1)
   );

   ppp_rotate u_rotate_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r1_valid),
      .vec_in    (r1),
      .mat       (mat_ff),
      .out_valid (r2_valid),
      .vec_out   (r2)
   );

   ppp_project u_project (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r2_valid),
      .vec_in    (r2),
      .focal     (focal_ff),
      .center_x  (CENTER_X),
      .center_y  (CENTER_Y),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

endmodule
